// ===== src/graph_bfs_dfs_traversal_unit_macros.svh =====
// assertion helpers for the traversal unit
`ifndef GRAPH_BFS_DFS_TRAVERSAL_UNIT_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_UNIT_MACROS_SVH

// same-cycle implication
`define GBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbt assertion failed");

// next-cycle implication
`define GBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbt assertion failed");

`endif

// ===== src/gbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbt_pkg;

    localparam int NUM_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 16;
    localparam int VTX_W            = 6;
    localparam int FUNC_W           = 2;
    localparam int STATUS_W         = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DFS      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BFS      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd2;

    // request from the sequencer to the result stage
    typedef struct packed {
        logic                produce;
        logic                finish;
        logic                direct;
        logic [VTX_W-1:0]    vtx;
        logic [STATUS_W-1:0] status;
    } t_out_ctl;

endpackage
`default_nettype wire

// ===== src/gbt_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbt_out
    import gbt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_out_ctl            i_ctl,
    output logic                     o_valid,
    output logic [VTX_W-1:0]         o_vertex,
    output logic                     o_last,
    output logic [STATUS_W-1:0]      o_status
);

    logic                r_pend_vld, n_pend_vld;
    logic [VTX_W-1:0]    r_pend, n_pend;
    logic                r_valid, n_valid;
    logic [VTX_W-1:0]    r_vertex, n_vertex;
    logic                r_last, n_last;
    logic [STATUS_W-1:0] r_status, n_status;

    // one visited vertex is held back so the final one can carry last
    always_comb begin
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_valid    = 1'b0;
        n_vertex   = r_vertex;
        n_last     = r_last;
        n_status   = r_status;
        priority if (i_ctl.direct) begin
            n_valid  = 1'b1;
            n_vertex = i_ctl.vtx;
            n_last   = 1'b1;
            n_status = i_ctl.status;
        end else if (i_ctl.produce) begin
            n_valid    = r_pend_vld;
            n_vertex   = r_pend;
            n_last     = 1'b0;
            n_status   = ST_OK;
            n_pend     = i_ctl.vtx;
            n_pend_vld = 1'b1;
        end else if (i_ctl.finish) begin
            n_valid    = 1'b1;
            n_vertex   = r_pend;
            n_last     = 1'b1;
            n_status   = ST_OK;
            n_pend_vld = 1'b0;
        end else begin
            n_valid    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            r_valid    <= n_valid;
        end
        r_pend   <= n_pend;
        r_vertex <= n_vertex;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_vertex = r_vertex;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule
`default_nettype wire

// ===== src/graph_bfs_dfs_traversal_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// graph traversal unit: undirected graph kept as per-vertex neighbor lists
// request channel: i_func, i_vertex_a, i_vertex_b taken when start is high and
//   busy is low; busy stays high until the request's last result is issued
// result channel: o_valid marks one result per cycle with o_visited_vertex,
//   o_last and o_status; the receiver cannot stall, results are never held
// add edge: two count reads and two list writes, then one result; range errors
//   answer on the next cycle
// depth-first: a count read per visited vertex, a list memory read then a check
//   per stored neighbor entry, and a stack memory read per stack pop
// breadth-first: a queue read and a count read per visited vertex, plus a list
//   memory read and a check per stored neighbor entry
// on a full 64-vertex, 16-degree graph the read and the check spent on every
//   stored neighbor entry take most of the run time
// each visited vertex is held back until the next is found or the walk ends so
//   the final one can carry o_last; requests with func 3 are taken and give no result
// reset clears counts, visited marks and the sequencer at once; no sweep
module graph_bfs_dfs_traversal_unit
    import gbt_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [VTX_W-1:0]    i_vertex_a,
    input  wire logic [VTX_W-1:0]    i_vertex_b,
    output logic                     o_valid,
    output logic [VTX_W-1:0]         o_visited_vertex,
    output logic                     o_last,
    output logic [STATUS_W-1:0]      o_status
);

`include "graph_bfs_dfs_traversal_unit_macros.svh"

    localparam int VW    = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int SPW   = $clog2(NUM_VERTICES + 1);
    localparam int CW    = $clog2(MAX_DEGREE + 1);
    localparam int AW    = $clog2(NUM_VERTICES * MAX_DEGREE);
    localparam int ENT_W = VTX_W + 2 * CW;
    localparam int LIST_DEPTH = NUM_VERTICES * MAX_DEGREE;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ERA   = 15'b000000000000010,
        S_ECHK  = 15'b000000000000100,
        S_EWB   = 15'b000000000001000,
        S_INIT  = 15'b000000000010000,
        S_DCNT  = 15'b000000000100000,
        S_DSTEP = 15'b000000001000000,
        S_DNB   = 15'b000000010000000,
        S_DPOP  = 15'b000000100000000,
        S_BDEQ  = 15'b000001000000000,
        S_BCUR  = 15'b000010000000000,
        S_BCNT  = 15'b000100000000000,
        S_BSTEP = 15'b001000000000000,
        S_BNB   = 15'b010000000000000,
        S_BIDLE = 15'b100000000000000
    } t_state;

    // memories
    logic [VTX_W-1:0]  nb_mem  [LIST_DEPTH];
    logic [CW-1:0]     cnt_mem [NUM_VERTICES];
    logic [ENT_W-1:0]  wl_mem  [NUM_VERTICES];

    logic [NUM_VERTICES-1:0] r_cnt_valid, n_cnt_valid;
    logic [NUM_VERTICES-1:0] r_visited, n_visited;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [VTX_W-1:0]    r_a, n_a;
    logic [VTX_W-1:0]    r_b, n_b;
    logic [CW-1:0]       r_ca, n_ca;
    logic [CW-1:0]       r_cb2, n_cb2;
    logic [VTX_W-1:0]    r_v, n_v;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SPW-1:0]      r_sp, n_sp;
    logic [SPW-1:0]      r_head, n_head;
    logic [SPW-1:0]      r_tail, n_tail;

    // memory ports
    logic [AW-1:0]       nb_raddr, nb_waddr;
    logic [VTX_W-1:0]    nb_wdata, r_nb_rd;
    logic                nb_we;
    logic [VW-1:0]       cnt_raddr, cnt_waddr;
    logic [CW-1:0]       cnt_wdata, r_cnt_rd, cnt_rdata;
    logic                cnt_we, r_cnt_rvld;
    logic [VW-1:0]       wl_raddr, wl_waddr;
    logic [ENT_W-1:0]    wl_wdata, r_wl_rd;
    logic                wl_we;

    t_out_ctl            out_ctl;
    logic                accept;
    logic [VTX_W-1:0]    w_vtx;
    logic                w_ok;
    logic [CW:0]         ca_plus2;

    assign accept    = start && (r_state == S_IDLE);
    assign cnt_rdata = r_cnt_rvld ? r_cnt_rd : '0;
    assign w_vtx     = r_nb_rd;
    assign w_ok      = ({1'b0, w_vtx} < (VTX_W + 1)'(NUM_VERTICES))
                       && !r_visited[w_vtx[VW-1:0]];
    assign ca_plus2  = {1'b0, r_ca} + (CW + 1)'(2);

    function automatic logic [AW-1:0] list_addr(input logic [VTX_W-1:0] v,
                                                input logic [CW-1:0] k);
        list_addr = AW'(v[VW-1:0]) * AW'(MAX_DEGREE) + AW'(k);
    endfunction

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_a         = r_a;
        n_b         = r_b;
        n_ca        = r_ca;
        n_cb2       = r_cb2;
        n_v         = r_v;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_sp        = r_sp;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt_valid = r_cnt_valid;
        n_visited   = r_visited;
        nb_raddr    = list_addr(r_v, r_k);
        nb_waddr    = list_addr(r_a, r_ca);
        nb_wdata    = r_b;
        nb_we       = 1'b0;
        cnt_raddr   = r_v[VW-1:0];
        cnt_waddr   = r_a[VW-1:0];
        cnt_wdata   = r_ca + CW'(1);
        cnt_we      = 1'b0;
        wl_raddr    = r_head[VW-1:0];
        wl_waddr    = r_tail[VW-1:0];
        wl_wdata    = {r_cnt, r_k, r_v};
        wl_we       = 1'b0;
        out_ctl     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_a    = i_vertex_a;
                    n_b    = i_vertex_b;
                    cnt_raddr = i_vertex_a[VW-1:0];
                    if (i_func == FUNC_ADD_EDGE) begin
                        if ({1'b0, i_vertex_a} >= (VTX_W + 1)'(NUM_VERTICES) ||
                            {1'b0, i_vertex_b} >= (VTX_W + 1)'(NUM_VERTICES)) begin
                            out_ctl.direct = 1'b1;
                            out_ctl.status = ST_RANGE;
                        end else begin
                            n_state = S_ERA;
                        end
                    end else if (i_func == FUNC_DFS || i_func == FUNC_BFS) begin
                        if ({1'b0, i_vertex_a} >= (VTX_W + 1)'(NUM_VERTICES)) begin
                            out_ctl.direct = 1'b1;
                            out_ctl.status = ST_RANGE;
                        end else begin
                            n_visited = '0;
                            n_state   = S_INIT;
                        end
                    end
                end
            end
            S_ERA: begin
                n_ca      = cnt_rdata;
                cnt_raddr = r_b[VW-1:0];
                n_state   = S_ECHK;
            end
            S_ECHK: begin
                if ((r_a == r_b) ? (ca_plus2 > (CW + 1)'(MAX_DEGREE))
                                 : (r_ca >= CW'(MAX_DEGREE) ||
                                    cnt_rdata >= CW'(MAX_DEGREE))) begin
                    out_ctl.direct = 1'b1;
                    out_ctl.status = ST_LIST_FULL;
                    n_state        = S_IDLE;
                end else begin
                    nb_we  = 1'b1;
                    cnt_we = 1'b1;
                    n_cnt_valid[r_a[VW-1:0]] = 1'b1;
                    n_cb2   = (r_a == r_b) ? (r_ca + CW'(1)) : cnt_rdata;
                    n_state = S_EWB;
                end
            end
            S_EWB: begin
                nb_we     = 1'b1;
                nb_waddr  = list_addr(r_b, r_cb2);
                nb_wdata  = r_a;
                cnt_we    = 1'b1;
                cnt_waddr = r_b[VW-1:0];
                cnt_wdata = r_cb2 + CW'(1);
                n_cnt_valid[r_b[VW-1:0]] = 1'b1;
                out_ctl.direct = 1'b1;
                out_ctl.status = ST_OK;
                n_state = S_IDLE;
            end
            S_INIT: begin
                n_visited[r_a[VW-1:0]] = 1'b1;
                if (r_func == FUNC_DFS) begin
                    out_ctl.produce = 1'b1;
                    out_ctl.vtx     = r_a;
                    n_v       = r_a;
                    n_k       = '0;
                    n_sp      = SPW'(1);
                    cnt_raddr = r_a[VW-1:0];
                    n_state   = S_DCNT;
                end else begin
                    wl_we    = 1'b1;
                    wl_waddr = '0;
                    wl_wdata = {{(2 * CW){1'b0}}, r_a};
                    n_head   = '0;
                    n_tail   = SPW'(1);
                    n_state  = S_BIDLE;
                end
            end
            S_DCNT: begin
                n_cnt   = cnt_rdata;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                if (r_k >= r_cnt) begin
                    if (r_sp == SPW'(1)) begin
                        out_ctl.finish = 1'b1;
                        n_sp    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_sp     = r_sp - SPW'(1);
                        wl_raddr = VW'(r_sp - SPW'(2));
                        n_state  = S_DPOP;
                    end
                end else begin
                    nb_raddr = list_addr(r_v, r_k);
                    n_k      = r_k + CW'(1);
                    n_state  = S_DNB;
                end
            end
            S_DNB: begin
                if (w_ok && r_sp < SPW'(NUM_VERTICES)) begin
                    n_visited[w_vtx[VW-1:0]] = 1'b1;
                    out_ctl.produce = 1'b1;
                    out_ctl.vtx     = w_vtx;
                    // current top moves into the stack memory
                    wl_we     = 1'b1;
                    wl_waddr  = VW'(r_sp - SPW'(1));
                    wl_wdata  = {r_cnt, r_k, r_v};
                    n_v       = w_vtx;
                    n_k       = '0;
                    n_sp      = r_sp + SPW'(1);
                    cnt_raddr = w_vtx[VW-1:0];
                    n_state   = S_DCNT;
                end else begin
                    n_state = S_DSTEP;
                end
            end
            S_DPOP: begin
                n_cnt   = r_wl_rd[ENT_W-1 -: CW];
                n_k     = r_wl_rd[VTX_W +: CW];
                n_v     = r_wl_rd[VTX_W-1:0];
                n_state = S_DSTEP;
            end
            S_BIDLE: begin
                n_state = S_BDEQ;
            end
            S_BDEQ: begin
                if (r_head == r_tail) begin
                    out_ctl.finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wl_raddr = r_head[VW-1:0];
                    n_head   = r_head + SPW'(1);
                    n_state  = S_BCUR;
                end
            end
            S_BCUR: begin
                n_v       = r_wl_rd[VTX_W-1:0];
                out_ctl.produce = 1'b1;
                out_ctl.vtx     = r_wl_rd[VTX_W-1:0];
                cnt_raddr = r_wl_rd[VW-1:0];
                n_state   = S_BCNT;
            end
            S_BCNT: begin
                n_cnt   = cnt_rdata;
                n_k     = '0;
                n_state = S_BSTEP;
            end
            S_BSTEP: begin
                if (r_k >= r_cnt) begin
                    n_state = S_BDEQ;
                end else begin
                    nb_raddr = list_addr(r_v, r_k);
                    n_k      = r_k + CW'(1);
                    n_state  = S_BNB;
                end
            end
            S_BNB: begin
                if (w_ok && r_tail < SPW'(NUM_VERTICES)) begin
                    n_visited[w_vtx[VW-1:0]] = 1'b1;
                    wl_we    = 1'b1;
                    wl_waddr = r_tail[VW-1:0];
                    wl_wdata = {{(2 * CW){1'b0}}, w_vtx};
                    n_tail   = r_tail + SPW'(1);
                end
                n_state = S_BSTEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_valid <= '0;
            r_visited   <= '0;
            r_sp        <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt_valid <= n_cnt_valid;
            r_visited   <= n_visited;
            r_sp        <= n_sp;
        end
        r_func <= n_func;
        r_a    <= n_a;
        r_b    <= n_b;
        r_ca   <= n_ca;
        r_cb2  <= n_cb2;
        r_v    <= n_v;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_head <= n_head;
        r_tail <= n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        r_nb_rd <= nb_mem[nb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd   <= cnt_mem[cnt_raddr];
        r_cnt_rvld <= r_cnt_valid[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wl_we) begin
            wl_mem[wl_waddr] <= wl_wdata;
        end
        r_wl_rd <= wl_mem[wl_raddr];
    end

    gbt_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (out_ctl),
        .o_valid  (o_valid),
        .o_vertex (o_visited_vertex),
        .o_last   (o_last),
        .o_status (o_status)
    );

    assign busy = (r_state != S_IDLE);

    `GBT_ASSERT_NOW(a_err_is_last, o_valid && o_status != ST_OK, o_last)
    `GBT_ASSERT_NEXT(a_last_gap, o_valid && o_last, !o_valid)
    `GBT_ASSERT_NOW(a_sp_bound, 1'b1, r_sp <= SPW'(NUM_VERTICES))
    `GBT_ASSERT_NEXT(a_trav_busy, accept && (i_func == FUNC_DFS) &&
                     ({1'b0, i_vertex_a} < (VTX_W + 1)'(NUM_VERTICES)), busy)

endmodule
`default_nettype wire

// ===== bench/graph_bfs_dfs_traversal_unit_tb.sv =====
`timescale 1ns / 1ps
module graph_bfs_dfs_traversal_unit_tb;
    import gbt_pkg::*;

    localparam int NV          = NUM_VERTICES_DEF;
    localparam int MAXDEG      = MAX_DEGREE_DEF;
    localparam int RAND_ITEMS  = 80;
    localparam int IDLE_ITEMS  = 60;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [VTX_W-1:0]    vtx;
        logic                last;
        logic [STATUS_W-1:0] status;
    } visit_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [VTX_W-1:0]    a;
        logic [VTX_W-1:0]    b;
        logic                typed;
        visit_t              want;
    } row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [VTX_W-1:0]    i_vertex_a = '0;
    logic [VTX_W-1:0]    i_vertex_b = '0;
    logic                busy;
    logic                o_valid;
    logic [VTX_W-1:0]    o_visited_vertex;
    logic                o_last;
    logic [STATUS_W-1:0] o_status;

    graph_bfs_dfs_traversal_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .o_valid(o_valid), .o_visited_vertex(o_visited_vertex),
        .o_last(o_last), .o_status(o_status)
    );

    always #5 i_clk = ~i_clk;

    // graph mirror
    logic [VTX_W-1:0] adj [NV][MAXDEG];
    int               degree [NV];
    bit               seen [NV];
    visit_t           pending_visits [$];
    int               errors = 0;
    int               quiet = 0;

    task automatic report(input string what, input visit_t got, input visit_t want);
        $display("mismatch %s: got v=%0d l=%0d s=%0d, want v=%0d l=%0d s=%0d",
                 what, got.vtx, got.last, got.status, want.vtx, want.last, want.status);
        errors++;
    endtask

    function automatic void emit(inout visit_t out [$], input int v, input logic [1:0] st);
        visit_t r;
        r.vtx = v[VTX_W-1:0];
        r.last = 1'b0;
        r.status = st;
        out.insert(out.size(), r);
    endfunction

    // updates the graph mirror and returns the visits a request causes
    function automatic void walk_graph(input logic [FUNC_W-1:0] f, input int a, input int b,
                                       output visit_t out [$]);
        int stk_v [$];
        int stk_k [$];
        int fifo [$];
        int v, k, w, top;
        out = {};
        if (f == FUNC_ADD_EDGE) begin
            if ((a == b) ? (degree[a] + 2 > MAXDEG)
                         : (degree[a] >= MAXDEG || degree[b] >= MAXDEG)) begin
                emit(out, 0, ST_LIST_FULL);
            end else begin
                adj[a][degree[a]] = b[VTX_W-1:0]; degree[a]++;
                adj[b][degree[b]] = a[VTX_W-1:0]; degree[b]++;
                emit(out, 0, ST_OK);
            end
        end else if (f == FUNC_DFS) begin
            foreach (seen[i]) seen[i] = 0;
            seen[a] = 1;
            emit(out, a, ST_OK);
            stk_v.insert(stk_v.size(), a); stk_k.insert(stk_k.size(), 0);
            while (stk_v.size() > 0) begin
                top = stk_v.size() - 1;
                v = stk_v[top]; k = stk_k[top];
                if (k >= degree[v]) begin
                    void'(stk_v.pop_back()); void'(stk_k.pop_back());
                end else begin
                    stk_k[top] = k + 1;
                    w = int'(adj[v][k]);
                    if (!seen[w]) begin
                        seen[w] = 1;
                        emit(out, w, ST_OK);
                        stk_v.insert(stk_v.size(), w); stk_k.insert(stk_k.size(), 0);
                    end
                end
            end
        end else if (f == FUNC_BFS) begin
            foreach (seen[i]) seen[i] = 0;
            seen[a] = 1;
            fifo.insert(fifo.size(), a);
            while (fifo.size() > 0) begin
                v = fifo.pop_front();
                emit(out, v, ST_OK);
                for (k = 0; k < degree[v]; k++) begin
                    w = int'(adj[v][k]);
                    if (!seen[w]) begin
                        seen[w] = 1;
                        fifo.insert(fifo.size(), w);
                    end
                end
            end
        end
        if (out.size() > 0) out[out.size()-1].last = 1'b1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        visit_t got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_visited_vertex, o_last, o_status};
            if (pending_visits.size() == 0) begin
                report("unexpected result", got, got);
            end else begin
                want = pending_visits.pop_front();
                if (got.vtx !== want.vtx) report("vertex", got, want);
                if (got.last !== want.last) report("last", got, want);
                if (got.status !== want.status) report("status", got, want);
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send(input logic [FUNC_W-1:0] f, input int a, input int b,
                        input bit allow_idle, input bit typed, input visit_t want);
        visit_t got [$];
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_vertex_a <= a[VTX_W-1:0];
        i_vertex_b <= b[VTX_W-1:0];
        do @(posedge i_clk); while (busy);
        walk_graph(f, a, b, got);
        if (typed) pending_visits.insert(pending_visits.size(), want);
        else foreach (got[i]) pending_visits.insert(pending_visits.size(), got[i]);
    endtask

    row_t directed [] = '{
        '{FUNC_DFS,      6'd0,  6'd0,  1'b1, '{6'd0,  1'b1, ST_OK}},
        '{FUNC_BFS,      6'd63, 6'd0,  1'b1, '{6'd63, 1'b1, ST_OK}},
        '{FUNC_ADD_EDGE, 6'd0,  6'd63, 1'b1, '{6'd0,  1'b1, ST_OK}},
        '{FUNC_ADD_EDGE, 6'd63, 6'd63, 1'b1, '{6'd0,  1'b1, ST_OK}},
        '{2'd3,          6'd63, 6'd63, 1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd3,  1'b0, '0},
        // one free slot left: self-loop needs two
        '{FUNC_ADD_EDGE, 6'd2,  6'd2,  1'b1, '{6'd0, 1'b1, ST_LIST_FULL}},
        '{FUNC_ADD_EDGE, 6'd2,  6'd0,  1'b0, '0},
        '{FUNC_ADD_EDGE, 6'd2,  6'd5,  1'b1, '{6'd0, 1'b1, ST_LIST_FULL}},
        '{FUNC_ADD_EDGE, 6'd5,  6'd2,  1'b1, '{6'd0, 1'b1, ST_LIST_FULL}},
        '{FUNC_ADD_EDGE, 6'd3,  6'd42, 1'b0, '0},
        '{FUNC_DFS,      6'd63, 6'd21, 1'b0, '0},
        '{FUNC_BFS,      6'd0,  6'd42, 1'b0, '0},
        '{FUNC_DFS,      6'd2,  6'd0,  1'b0, '0},
        '{FUNC_BFS,      6'd42, 6'd63, 1'b0, '0}
    };

    initial begin
        int pick, a, b;
        foreach (degree[i]) degree[i] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i])
            send(directed[i].func, directed[i].a, directed[i].b, 1'b1,
                 directed[i].typed, directed[i].want);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            // a small vertex pool fills lists and links components
            a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, NV - 1);
            b = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, NV - 1);
            if (pick < 12) send(FUNC_ADD_EDGE, a, b, n < IDLE_ITEMS, 1'b0, '0);
            else if (pick < 15) send(FUNC_DFS, a, b, n < IDLE_ITEMS, 1'b0, '0);
            else if (pick < 18) send(FUNC_BFS, a, b, n < IDLE_ITEMS, 1'b0, '0);
            else send(2'd3, a, b, n < IDLE_ITEMS, 1'b0, '0);
        end
        start <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== graph_bfs_dfs_traversal_unit.f =====
+incdir+src
src/gbt_pkg.sv
src/gbt_out.sv
src/graph_bfs_dfs_traversal_unit.sv
bench/graph_bfs_dfs_traversal_unit_tb.sv
